// ===== rtl/core/rlelit_pkg.sv =====
package rlelit_pkg;

    localparam int          MAX_RUN_DEF = 9;
    localparam int          CNT_W       = 4;
    localparam int          MAX_OUT     = 5;
    localparam int          OCNT_W      = 3;

    localparam logic [7:0]  DELIM       = 8'h31;
    localparam logic [7:0]  NEWLINE     = 8'h0A;
    localparam logic [7:0]  DIGIT_ZERO  = 8'h30;

    localparam logic        OP_CHAR     = 1'b0;
    localparam logic        OP_EOL      = 1'b1;

endpackage

// ===== rtl/core/run_length_encoder_literal_escape_top.sv =====
// Run-length encoder with literal escape, one byte of lookahead.
// Input channel (i_in_valid / o_in_ready): i_opcode selects a line character
// (i_char_byte) or an end of line, which flushes the held run or literal and
// sends a newline. Output channel (o_out_valid / i_out_ready): one encoded
// byte per transfer; o_last_of_run marks the final byte caused by one input.
// An input yields zero to five bytes. Its bytes are worked out in the cycle
// of the input transfer and loaded into a five-entry shift buffer that feeds
// the output register; a byte shows only once it has moved on into that register.
// The output register drains the buffer at one byte per cycle while the
// receiver is ready. A new input is taken while the buffer's last byte
// moves into the output register, so a waiting result never blocks intake
// for more than its own drain.
// When the receiver stalls, the output register holds its byte and the
// buffer holds the rest; intake stops while the buffer holds any byte.
// Synchronous reset clears the held byte, the run count, the open literal
// segment, the buffer count and the output valid.
module run_length_encoder_literal_escape_top #(
    parameter int MAX_RUN = rlelit_pkg::MAX_RUN_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_opcode,
    input  logic [7:0] i_char_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run
);

    localparam int CW = rlelit_pkg::CNT_W;
    localparam int NO = rlelit_pkg::MAX_OUT;
    localparam int OW = rlelit_pkg::OCNT_W;
    localparam logic [CW-1:0] MAX_RUN_C = CW'(MAX_RUN);

    logic [7:0]    r_held, n_held;
    logic [CW-1:0] r_run, n_run;
    logic          r_lit, n_lit;

    logic [7:0]    r_buf [NO];
    logic [OW-1:0] r_bcnt;
    logic          r_ov;
    logic [7:0]    r_ob;
    logic          r_ol;

    logic [7:0]    v_bytes [NO];
    logic [OW-1:0] v_n;
    logic [CW-1:0] v_inc;
    logic          in_xfer;
    logic          buf_mv;

    assign buf_mv     = (r_bcnt != '0) && (!r_ov || i_out_ready);
    assign o_in_ready = (r_bcnt == '0) || ((r_bcnt == OW'(1)) && buf_mv);
    assign in_xfer    = i_in_valid && o_in_ready;

    always_comb begin
        n_held = r_held;
        n_run  = r_run;
        n_lit  = r_lit;
        v_n    = '0;
        v_inc  = r_run + CW'(1);
        for (int k = 0; k < NO; k++) begin
            v_bytes[k] = rlelit_pkg::NEWLINE;
        end
        if (i_opcode == rlelit_pkg::OP_CHAR) begin
            if (r_run == '0) begin
                n_held = i_char_byte;
                n_run  = CW'(1);
            end else if (i_char_byte == r_held) begin
                if ((r_run == CW'(1)) && r_lit) begin
                    v_bytes[v_n] = rlelit_pkg::DELIM;
                    v_n = v_n + OW'(1);
                    n_lit = 1'b0;
                end
                n_run = v_inc;
                if (v_inc >= MAX_RUN_C) begin
                    v_bytes[v_n] = rlelit_pkg::DIGIT_ZERO + {{(8-CW){1'b0}}, v_inc};
                    v_n = v_n + OW'(1);
                    v_bytes[v_n] = r_held;
                    v_n = v_n + OW'(1);
                    n_run = '0;
                end
            end else begin
                if (r_run >= CW'(2)) begin
                    v_bytes[v_n] = rlelit_pkg::DIGIT_ZERO + {{(8-CW){1'b0}}, r_run};
                    v_n = v_n + OW'(1);
                    v_bytes[v_n] = r_held;
                    v_n = v_n + OW'(1);
                end else begin
                    if (!r_lit) begin
                        v_bytes[v_n] = rlelit_pkg::DELIM;
                        v_n = v_n + OW'(1);
                        n_lit = 1'b1;
                    end
                    if (r_held == rlelit_pkg::DELIM) begin
                        v_bytes[v_n] = rlelit_pkg::DELIM;
                        v_n = v_n + OW'(1);
                    end
                    v_bytes[v_n] = r_held;
                    v_n = v_n + OW'(1);
                end
                n_held = i_char_byte;
                n_run  = CW'(1);
            end
        end else begin
            if (r_run >= CW'(2)) begin
                v_bytes[v_n] = rlelit_pkg::DIGIT_ZERO + {{(8-CW){1'b0}}, r_run};
                v_n = v_n + OW'(1);
                v_bytes[v_n] = r_held;
                v_n = v_n + OW'(1);
            end else if (r_run == CW'(1)) begin
                if (!n_lit) begin
                    v_bytes[v_n] = rlelit_pkg::DELIM;
                    v_n = v_n + OW'(1);
                    n_lit = 1'b1;
                end
                if (r_held == rlelit_pkg::DELIM) begin
                    v_bytes[v_n] = rlelit_pkg::DELIM;
                    v_n = v_n + OW'(1);
                end
                v_bytes[v_n] = r_held;
                v_n = v_n + OW'(1);
            end
            if (n_lit) begin
                v_bytes[v_n] = rlelit_pkg::DELIM;
                v_n = v_n + OW'(1);
                n_lit = 1'b0;
            end
            v_bytes[v_n] = rlelit_pkg::NEWLINE;
            v_n = v_n + OW'(1);
            n_held = '0;
            n_run  = '0;
        end
    end

    // encoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            r_run  <= '0;
            r_lit  <= 1'b0;
        end else if (in_xfer) begin
            r_held <= n_held;
            r_run  <= n_run;
            r_lit  <= n_lit;
        end
    end

    // result buffer, shifts toward entry 0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bcnt <= '0;
        end else if (in_xfer) begin
            r_bcnt <= v_n;
        end else if (buf_mv) begin
            r_bcnt <= r_bcnt - OW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            for (int k = 0; k < NO; k++) begin
                r_buf[k] <= v_bytes[k];
            end
        end else if (buf_mv) begin
            for (int k = 0; k < NO - 1; k++) begin
                r_buf[k] <= r_buf[k+1];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (buf_mv) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (buf_mv) begin
            r_ob <= r_buf[0];
            r_ol <= (r_bcnt == OW'(1));
        end
    end

    assign o_out_valid   = r_ov;
    assign o_out_byte    = r_ob;
    assign o_last_of_run = r_ol;

endmodule

// ===== rtl/core/rlelit_checker.sv =====
module rlelit_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       i_opcode,
    input logic [7:0] i_char_byte,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_out_byte,
    input logic       o_last_of_run
);

    // stalled transfer holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_byte)
            && $stable(o_last_of_run))
        else $error("output changed while stalled");

    // offered input stays put until taken
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_opcode)
            && $stable(i_char_byte))
        else $error("input changed while stalled");

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // intake blocked only while results are pending
    a_block_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |=> o_out_valid)
        else $error("intake blocked with nothing to send");

    // bytes of one input go out without gaps
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_last_of_run |=> o_out_valid)
        else $error("gap inside one input's results");

endmodule

bind run_length_encoder_literal_escape_top rlelit_checker u_rlelit_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .i_opcode      (i_opcode),
    .i_char_byte   (i_char_byte),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_out_byte    (o_out_byte),
    .o_last_of_run (o_last_of_run)
);
